// ===== rtl/core/sir_pkg.sv =====
package sir_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned QUOT_W = 22;
  localparam int unsigned STEP_CNT_W = 5;

  localparam logic [DATA_W-1:0] CLOCK_HZ = 32'd3546895;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd124;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
  localparam logic [DATA_W-1:0] LEN_MAX = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] LEN_SAT = 32'hFFFF_FFFE;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = 5'(QUOT_W - 1);

endpackage

// ===== rtl/core/sir_ifs.sv =====
interface sir_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sir_pkg::DATA_W-1:0]  raw_bank_bytes;

  modport source (output valid, output raw_bank_bytes, input ready);
  modport sink (input valid, input raw_bank_bytes, output ready);
endinterface

interface sir_rec_if;
  logic                        valid;
  logic                        ready;
  logic                        new_bank;
  logic [sir_pkg::DATA_W-1:0]  sample_offset;
  logic [sir_pkg::DATA_W-1:0]  sample_length;
  logic [sir_pkg::DATA_W-1:0]  sample_rate;

  modport source (output valid, output new_bank, output sample_offset,
                  output sample_length, output sample_rate, input ready);
  modport sink (input valid, input new_bank, input sample_offset,
                input sample_length, input sample_rate, output ready);
endinterface

interface sir_lay_if;
  logic                          valid;
  logic                          ready;
  logic [sir_pkg::DATA_W-1:0]    bank_offset;
  logic [sir_pkg::DATA_W-1:0]    padded_length;
  logic [sir_pkg::PERIOD_W-1:0]  play_period;
  logic [sir_pkg::PERIOD_W-1:0]  rate_out;
  logic                          dropped;
  logic [sir_pkg::DATA_W-1:0]    bank_total;

  modport source (output valid, output bank_offset, output padded_length,
                  output play_period, output rate_out, output dropped,
                  output bank_total, input ready);
  modport sink (input valid, input bank_offset, input padded_length,
                input play_period, input rate_out, input dropped,
                input bank_total, output ready);
endinterface

// ===== rtl/core/sample_index_repacker.sv =====
// A record that needs a period waits for the 22 one-bit steps of the restoring
// divider; a hole or a zero rate skips the divider. One request is in flight at a
// time; a new request is taken only after the result handshake for the last one.
// Reset (synchronous, active high) clears the running offset and the bank size register.
module sample_index_repacker #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  sir_cfg_if.sink     cfg,
  sir_rec_if.sink     rec,
  sir_lay_if.source   lay
);

  typedef enum logic [1:0] {
    IDLE,
    CALC,
    DIV_WAIT,
    SEND
  } state_t;

  state_t                          state;
  logic [sir_pkg::DATA_W-1:0]      raw_bank_bytes;
  logic [OFFSET_WIDTH-1:0]         running_offset;

  logic                            nb;
  logic [sir_pkg::DATA_W-1:0]      off;
  logic [sir_pkg::DATA_W-1:0]      len;
  logic [sir_pkg::DATA_W-1:0]      rate;

  logic [sir_pkg::DATA_W-1:0]      bank_offset;
  logic [sir_pkg::DATA_W-1:0]      padded_length;
  logic [sir_pkg::PERIOD_W-1:0]    play_period;
  logic [sir_pkg::PERIOD_W-1:0]    rate_out;
  logic                            dropped;
  logic [sir_pkg::DATA_W-1:0]      bank_total;

  logic [OFFSET_WIDTH-1:0]         base;
  logic [OFFSET_WIDTH-1:0]         advanced;
  logic [sir_pkg::DATA_W-1:0]      room;
  logic                            outside;
  logic                            hole;
  logic [sir_pkg::DATA_W-1:0]      even;
  logic [sir_pkg::PERIOD_W-1:0]    rate_sat;
  logic                            div_start;
  logic [sir_pkg::DATA_W-1:0]      dividend;
  logic                            div_done;
  logic [sir_pkg::QUOT_W-1:0]      quotient;
  logic [sir_pkg::PERIOD_W-1:0]    period_clamped;

  assign cfg.ready = 1'b1;
  assign rec.ready = (state == IDLE);

  assign base = nb ? '0 : running_offset;
  assign room = raw_bank_bytes - off;
  assign outside = (off > raw_bank_bytes) || (len > room);
  assign hole = (len == '0) || outside;
  assign even = (len == sir_pkg::LEN_MAX) ? sir_pkg::LEN_SAT :
                (len + {{(sir_pkg::DATA_W-1){1'b0}}, len[0]});
  assign advanced = base + even[OFFSET_WIDTH-1:0];
  assign rate_sat = (rate[sir_pkg::DATA_W-1:sir_pkg::PERIOD_W] != '0) ?
                    sir_pkg::PERIOD_MAX : rate[sir_pkg::PERIOD_W-1:0];
  assign dividend = sir_pkg::CLOCK_HZ + {1'b0, rate[sir_pkg::DATA_W-1:1]};
  assign div_start = (state == CALC) && !hole && (rate != '0);

  assign period_clamped =
    (quotient[sir_pkg::QUOT_W-1:sir_pkg::PERIOD_W] != '0) ? sir_pkg::PERIOD_MAX :
    (quotient[sir_pkg::PERIOD_W-1:0] < sir_pkg::PERIOD_MIN) ? sir_pkg::PERIOD_MIN :
    quotient[sir_pkg::PERIOD_W-1:0];

  sir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (rate),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      raw_bank_bytes <= '0;
      running_offset <= '0;
    end else begin
      if (cfg.valid) begin
        raw_bank_bytes <= cfg.raw_bank_bytes;
      end
      unique case (state)
        IDLE: begin
          if (rec.valid) begin
            nb <= rec.new_bank;
            off <= rec.sample_offset;
            len <= rec.sample_length;
            rate <= rec.sample_rate;
            state <= CALC;
          end
        end
        CALC: begin
          if (hole) begin
            running_offset <= base;
            bank_offset <= '0;
            padded_length <= '0;
            play_period <= '0;
            rate_out <= '0;
            dropped <= (len != '0);
            bank_total <= sir_pkg::DATA_W'(base);
            state <= SEND;
          end else begin
            running_offset <= advanced;
            bank_offset <= sir_pkg::DATA_W'(base);
            padded_length <= even;
            play_period <= sir_pkg::PERIOD_MIN;
            rate_out <= rate_sat;
            dropped <= 1'b0;
            bank_total <= sir_pkg::DATA_W'(advanced);
            state <= (rate == '0) ? SEND : DIV_WAIT;
          end
        end
        DIV_WAIT: begin
          if (div_done) begin
            play_period <= period_clamped;
            state <= SEND;
          end
        end
        SEND: begin
          if (lay.ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign lay.valid = (state == SEND);
  assign lay.bank_offset = bank_offset;
  assign lay.padded_length = padded_length;
  assign lay.play_period = play_period;
  assign lay.rate_out = rate_out;
  assign lay.dropped = dropped;
  assign lay.bank_total = bank_total;

endmodule

// ===== rtl/core/sir_div.sv =====
module sir_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sir_pkg::DATA_W-1:0]   dividend,
  input  logic [sir_pkg::DATA_W-1:0]   divisor,
  output logic                         done,
  output logic [sir_pkg::QUOT_W-1:0]   quotient
);

  logic                              busy;
  logic [sir_pkg::STEP_CNT_W-1:0]    step;
  logic [sir_pkg::DATA_W-1:0]        rem;
  logic [sir_pkg::QUOT_W-1:0]        bits;
  logic [sir_pkg::DATA_W-1:0]        dvs;
  logic [sir_pkg::DATA_W:0]          shifted;
  logic [sir_pkg::DATA_W+1:0]        diff;

  // The quotient always fits in QUOT_W bits, so the top dividend bits start
  // out below the divisor and only the low QUOT_W bits need a step each.
  assign shifted = {rem, bits[sir_pkg::QUOT_W-1]};
  assign diff = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem <= {{sir_pkg::QUOT_W{1'b0}}, dividend[sir_pkg::DATA_W-1:sir_pkg::QUOT_W]};
        bits <= dividend[sir_pkg::QUOT_W-1:0];
        dvs <= divisor;
      end else if (busy) begin
        if (diff[sir_pkg::DATA_W+1]) begin
          rem <= shifted[sir_pkg::DATA_W-1:0];
          bits <= {bits[sir_pkg::QUOT_W-2:0], 1'b0};
        end else begin
          rem <= diff[sir_pkg::DATA_W-1:0];
          bits <= {bits[sir_pkg::QUOT_W-2:0], 1'b1};
        end
        step <= step + 1'b1;
        if (step == sir_pkg::LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  assign quotient = bits;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT = 9;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic                       new_bank;
    logic [sir_pkg::DATA_W-1:0] sample_offset;
    logic [sir_pkg::DATA_W-1:0] sample_length;
    logic [sir_pkg::DATA_W-1:0] sample_rate;
  } record_t;

  typedef struct packed {
    logic [sir_pkg::DATA_W-1:0]   bank_offset;
    logic [sir_pkg::DATA_W-1:0]   padded_length;
    logic [sir_pkg::PERIOD_W-1:0] play_period;
    logic [sir_pkg::PERIOD_W-1:0] rate_out;
    logic                         dropped;
    logic [sir_pkg::DATA_W-1:0]   bank_total;
  } layout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sir_cfg_if cfg_if ();
  sir_rec_if rec_if ();
  sir_lay_if lay_if ();

  sample_index_repacker #(
    .OFFSET_WIDTH(32)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .rec(rec_if),
    .lay(lay_if)
  );

  logic [sir_pkg::DATA_W-1:0] bank_size = '0;
  logic [sir_pkg::DATA_W-1:0] run_offset = '0;
  layout_t expected_layouts[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit steady_flow = 1'b0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      lay_if.ready <= 1'b0;
    end else begin
      lay_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic report_mismatch(input string what, input logic [sir_pkg::DATA_W-1:0] got,
                                 input logic [sir_pkg::DATA_W-1:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
    end
    mismatch_count++;
  endtask

  function automatic layout_t predict_layout(input record_t r);
    layout_t l;
    logic [63:0] quot;
    logic [sir_pkg::DATA_W-1:0] even;
    logic outside;
    l = '0;
    if (r.new_bank) begin
      run_offset = '0;
    end
    outside = (r.sample_offset > bank_size) ||
              (r.sample_length > bank_size - r.sample_offset);
    if (r.sample_length == '0 || outside) begin
      l.dropped = (r.sample_length != '0);
      l.bank_total = run_offset;
      return l;
    end
    even = (r.sample_length == sir_pkg::LEN_MAX) ? sir_pkg::LEN_SAT :
           ((r.sample_length + 32'd1) & ~32'd1);
    if (r.sample_rate == '0) begin
      l.play_period = sir_pkg::PERIOD_MIN;
    end else begin
      quot = (64'(sir_pkg::CLOCK_HZ) + 64'(r.sample_rate >> 1)) / 64'(r.sample_rate);
      if (quot < 64'(sir_pkg::PERIOD_MIN)) begin
        l.play_period = sir_pkg::PERIOD_MIN;
      end else if (quot > 64'(sir_pkg::PERIOD_MAX)) begin
        l.play_period = sir_pkg::PERIOD_MAX;
      end else begin
        l.play_period = quot[sir_pkg::PERIOD_W-1:0];
      end
    end
    l.rate_out = (r.sample_rate > 32'(sir_pkg::PERIOD_MAX)) ? sir_pkg::PERIOD_MAX :
                 r.sample_rate[sir_pkg::PERIOD_W-1:0];
    l.bank_offset = run_offset;
    l.padded_length = even;
    run_offset = run_offset + even;
    l.bank_total = run_offset;
    return l;
  endfunction

  always @(posedge clk) begin
    layout_t want;
    if (!rst && lay_if.valid && lay_if.ready) begin
      if (expected_layouts.size() == 0) begin
        report_mismatch("unexpected layout", lay_if.bank_offset, '0);
      end else begin
        want = expected_layouts.pop_front();
        if (lay_if.bank_offset !== want.bank_offset)
          report_mismatch("bank_offset", lay_if.bank_offset, want.bank_offset);
        if (lay_if.padded_length !== want.padded_length)
          report_mismatch("padded_length", lay_if.padded_length, want.padded_length);
        if (lay_if.play_period !== want.play_period)
          report_mismatch("play_period", 32'(lay_if.play_period), 32'(want.play_period));
        if (lay_if.rate_out !== want.rate_out)
          report_mismatch("rate_out", 32'(lay_if.rate_out), 32'(want.rate_out));
        if (lay_if.dropped !== want.dropped)
          report_mismatch("dropped", 32'(lay_if.dropped), 32'(want.dropped));
        if (lay_if.bank_total !== want.bank_total)
          report_mismatch("bank_total", lay_if.bank_total, want.bank_total);
      end
    end
  end

  // Called and left at a falling edge; valid stays high so that back-to-back
  // requests are possible, and it is lowered for random idle gaps and on a drain.
  task automatic send_record(input record_t r);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      rec_if.valid <= 1'b0;
      @(negedge clk);
    end
    rec_if.valid <= 1'b1;
    rec_if.new_bank <= r.new_bank;
    rec_if.sample_offset <= r.sample_offset;
    rec_if.sample_length <= r.sample_length;
    rec_if.sample_rate <= r.sample_rate;
    do @(posedge clk); while (!rec_if.ready);
    expected_layouts.push_back(predict_layout(r));
    @(negedge clk);
  endtask

  task automatic send_fields(input logic nb, input logic [sir_pkg::DATA_W-1:0] off,
                             input logic [sir_pkg::DATA_W-1:0] len,
                             input logic [sir_pkg::DATA_W-1:0] rate);
    record_t r;
    r = '{new_bank: nb, sample_offset: off, sample_length: len, sample_rate: rate};
    send_record(r);
  endtask

  task automatic wait_layouts_drained();
    rec_if.valid <= 1'b0;
    while (expected_layouts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_bank_size(input logic [sir_pkg::DATA_W-1:0] size);
    wait_layouts_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.raw_bank_bytes <= size;
    do @(posedge clk); while (!cfg_if.ready);
    bank_size = size;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [sir_pkg::DATA_W-1:0] random_rate();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(60, 1);
      2, 3: return $urandom_range(32'd200000, 32'd28000);
      4: return $urandom();
      default: return $urandom_range(48000, 4000);
    endcase
  endfunction

  // Mostly records that fit the bank, with zero lengths, overlong lengths and
  // offsets past the end mixed in.
  function automatic record_t random_record();
    record_t r;
    logic [sir_pkg::DATA_W-1:0] room;
    r.new_bank = ($urandom_range(0, 15) == 0);
    r.sample_rate = random_rate();
    r.sample_offset = (bank_size == '0) ? '0 : $urandom_range(bank_size, 0);
    room = bank_size - r.sample_offset;
    case ($urandom_range(0, 9))
      0: r.sample_length = '0;
      1: begin
        if (room != sir_pkg::LEN_MAX) begin
          r.sample_length = $urandom_range(sir_pkg::LEN_MAX, room + 1);
        end else begin
          r.sample_length = $urandom();
        end
      end
      2: begin
        if (bank_size != sir_pkg::LEN_MAX) begin
          r.sample_offset = $urandom_range(sir_pkg::LEN_MAX, bank_size + 1);
        end
        r.sample_length = $urandom();
      end
      default: begin
        if (room == '0) begin
          r.sample_length = '0;
        end else if ($urandom_range(0, 1) == 0) begin
          r.sample_length = $urandom_range((room > 32'd4096) ? 32'd4096 : room, 1);
        end else begin
          r.sample_length = $urandom_range(room, 1);
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_random_records(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_record(random_record());
    end
  endtask

  task automatic test_empty_bank_after_reset();
    send_fields(1'b0, 32'd0, 32'd0, 32'd8000);
    send_fields(1'b0, 32'd0, 32'd5, 32'd8000);
    send_fields(1'b1, 32'd3, 32'd0, 32'd0);
  endtask

  task automatic test_directed_extremes();
    write_bank_size(sir_pkg::LEN_MAX);
    send_fields(1'b1, 32'd0, sir_pkg::LEN_MAX, 32'd8000);
    send_fields(1'b0, 32'd0, 32'd3, 32'd0);
    send_fields(1'b0, sir_pkg::LEN_MAX, 32'd0, sir_pkg::LEN_MAX);
    send_fields(1'b0, sir_pkg::LEN_MAX, 32'd1, 32'd11025);
    send_fields(1'b0, 32'hFFFF_FFFE, 32'd1, 32'd1);
    send_fields(1'b0, 32'd0, 32'd1, 32'd54);
    send_fields(1'b0, 32'd0, 32'd2, 32'd55);
    send_fields(1'b0, 32'd7, 32'd9999, 32'd28604);
    send_fields(1'b0, 32'd7, 32'd10, 32'd28605);
    send_fields(1'b0, 32'd7, 32'd10, 32'd65535);
    send_fields(1'b0, 32'd7, 32'd10, 32'd65536);
    send_fields(1'b0, 32'd7, 32'd10, 32'd7093790);
    send_fields(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, sir_pkg::LEN_MAX);
    send_fields(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_fields(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    send_fields(1'b0, 32'd0, 32'd1, 32'd2);
    write_bank_size(32'd100);
    send_fields(1'b0, 32'd100, 32'd1, 32'd22050);
    send_fields(1'b0, 32'd101, 32'd0, 32'd22050);
    send_fields(1'b0, 32'd50, 32'd50, 32'd22050);
    send_fields(1'b0, 32'd50, 32'd51, 32'd22050);
  endtask

  task automatic test_random_small_bank();
    write_bank_size(32'd1024);
    send_random_records(100);
  endtask

  task automatic test_random_mid_bank();
    write_bank_size($urandom_range(32'h00FF_FFFF, 32'h0001_0000));
    send_random_records(75);
    wait_layouts_drained();
    send_random_records(75);
  endtask

  task automatic test_random_full_bank();
    write_bank_size(sir_pkg::LEN_MAX);
    steady_flow = 1'b1;
    send_random_records(60);
    steady_flow = 1'b0;
    send_random_records(90);
  endtask

  task automatic test_bank_size_zero();
    write_bank_size('0);
    send_random_records(10);
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.raw_bank_bytes = '0;
    rec_if.valid = 1'b0;
    rec_if.new_bank = 1'b0;
    rec_if.sample_offset = '0;
    rec_if.sample_length = '0;
    rec_if.sample_rate = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_bank_after_reset();
    test_directed_extremes();
    test_random_small_bank();
    test_random_mid_bank();
    test_random_full_bank();
    test_bank_size_zero();
    wait_layouts_drained();
    if (mismatch_count == 0 && expected_layouts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sir_pkg.sv
rtl/core/sir_ifs.sv
rtl/core/sir_div.sv
rtl/core/sample_index_repacker.sv
tb/sv/tb_top.sv
